FILE: sv/wildcard_byte_pattern_scan_core_defines.svh
// assertion helpers for the checker file
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define WBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// next-cycle implication, off while in reset
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

// next-cycle implication, checked through reset as well
`define WBPS_ASSERT_NEXT_ALL(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

FILE: sv/wbps_pkg.sv
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int ADDRESS_BITS      = 32;
    localparam int CELL_COUNT        = MAX_PATTERN_BYTES - 1;
    localparam int FILL_W            = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W             = 5;
    localparam int CFG_W             = 64;
    localparam int BASE_W            = 32;
    localparam int CFG_IDX_W         = 2;

    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2,
        CFG_BASE     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    function automatic logic byte_hit(input logic [7:0] pat, input logic [7:0] data);
        return (pat == WILDCARD_BYTE) || (pat == data);
    endfunction

endpackage

FILE: sv/wbps_cell.sv
module wbps_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbps_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_pat,
    input  logic                i_use,
    output logic [7:0]          o_byte,
    output logic                o_hit
);
    import wbps_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // compare against the byte entering this position
    assign o_hit  = !i_use || byte_hit(i_pat, i_byte);
    assign o_byte = r_byte;

endmodule

FILE: sv/wildcard_byte_pattern_scan_core.sv
// a result is registered in the output register on the clock edge that accepts its item
// throughput: one byte per cycle while the result side does not stall, as all window positions compare at once
// a byte is taken while the held result waits, as long as the result side is ready
// reset (synchronous, active low) clears the window, offset, fill count and
// match flag, and resets the config and output valid; found flag and address are not reset
module wildcard_byte_pattern_scan_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_region_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_found,
    output logic [31:0]                    o_match_address
);
    import wbps_pkg::*;

    logic [63:0]             r_pat_low;
    logic [63:0]             r_pat_high;
    logic [LEN_W-1:0]        r_len;
    logic [BASE_W-1:0]       r_base;
    logic [ADDRESS_BITS-1:0] r_offset;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_reported;
    logic                    r_out_valid;
    logic                    r_found;
    logic [31:0]             r_addr;

    logic [ADDRESS_BITS-1:0] n_offset;
    logic [FILL_W-1:0]       n_fill;
    logic [ADDRESS_BITS-1:0] n_addr;

    logic [7:0]              pat_arr [MAX_PATTERN_BYTES];
    logic [7:0]              pos_pat [MAX_PATTERN_BYTES];
    logic                    pos_use [MAX_PATTERN_BYTES];
    logic [7:0]              win     [CELL_COUNT];
    logic [MAX_PATTERN_BYTES-1:0] hits;
    logic [FILL_W-1:0]       len_c;
    t_cell_ctl               cell_ctl;

    logic in_acc;
    logic upd;
    logic match;
    logic not_found;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_pat
            if (g < 8) begin : g_lo
                assign pat_arr[g] = r_pat_low[8*g +: 8];
            end else if (g < 16) begin : g_hi
                assign pat_arr[g] = r_pat_high[8*(g-8) +: 8];
            end else begin : g_wc
                assign pat_arr[g] = WILDCARD_BYTE;
            end
        end
    endgenerate

    assign len_c = (int'(r_len) > MAX_PATTERN_BYTES) ? FILL_W'(MAX_PATTERN_BYTES)
                                                     : FILL_W'(r_len);

    // window position k, newest first, meets pattern byte len-1-k
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            pos_use[k] = (k < int'(len_c));
            pos_pat[k] = pat_arr[PAT_IDX_W'(int'(len_c) - 1 - k)];
        end
    end

    assign in_acc = i_in_valid && o_in_ready;
    assign upd    = in_acc && !r_reported;

    assign cell_ctl.shift = upd;
    assign cell_ctl.clear = in_acc && i_region_end;

    generate
        for (g = 0; g < CELL_COUNT; g++) begin : g_cell
            wbps_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (cell_ctl),
                .i_byte ((g == 0) ? i_data_byte : win[(g == 0) ? 0 : g-1]),
                .i_pat  (pos_pat[g]),
                .i_use  (pos_use[g]),
                .o_byte (win[g]),
                .o_hit  (hits[g])
            );
        end
    endgenerate

    // oldest position reads the last stored byte
    assign hits[MAX_PATTERN_BYTES-1] = !pos_use[MAX_PATTERN_BYTES-1] ||
        byte_hit(pos_pat[MAX_PATTERN_BYTES-1], win[CELL_COUNT-1]);

    assign n_fill   = (int'(r_fill) == MAX_PATTERN_BYTES) ? r_fill : r_fill + FILL_W'(1);
    assign n_offset = r_offset + ADDRESS_BITS'(1);
    assign n_addr   = ADDRESS_BITS'(r_base) + n_offset - ADDRESS_BITS'(len_c);

    assign match     = upd && (len_c != '0) && (n_fill >= len_c) && (&hits);
    assign not_found = in_acc && i_region_end && !r_reported && !match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= LEN_W'(1);
            r_base     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data[63:0];
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data[63:0];
                CFG_PAT_LEN:  r_len      <= i_cfg_data[LEN_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_fill     <= '0;
            r_reported <= 1'b0;
        end else if (in_acc) begin
            if (i_region_end) begin
                r_offset   <= '0;
                r_fill     <= '0;
                r_reported <= 1'b0;
            end else if (upd) begin
                r_offset   <= n_offset;
                r_fill     <= n_fill;
                r_reported <= match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (match || not_found) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            r_found <= 1'b1;
            r_addr  <= 32'(n_addr);
        end else if (not_found) begin
            r_found <= 1'b0;
            r_addr  <= '0;
        end
    end

    assign o_in_ready      = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule

FILE: sv/wbps_checker.sv
`include "wildcard_byte_pattern_scan_core_defines.svh"

module wbps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_found,
    input logic [31:0] o_match_address
);

    // not-found result always carries a zero address
    `WBPS_ASSERT_NOW(a_notfound_zero, o_out_valid && !o_found, o_match_address == 32'd0)

    // an empty output register never holds back the input side
    `WBPS_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    // a stalled result holds its fields
    `WBPS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_found) && $stable(o_match_address))

    // no result right after reset
    `WBPS_ASSERT_NEXT_ALL(a_reset_empty, !i_rst_n, !o_out_valid)

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic        found;
        logic [31:0] addr;
    } scan_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PAT_LOW;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_region_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_found;
    logic [31:0]          o_match_address;

    // scanner copy: registers
    logic [63:0] pat_low = '0;
    logic [63:0] pat_high = '0;
    logic [4:0]  pat_len = 5'd1;
    logic [31:0] base_addr = '0;

    // scanner copy: region state
    logic [7:0]  win [16];
    logic [31:0] scan_offset = '0;
    logic        match_seen = 1'b0;
    int          fill = 0;

    scan_result_t expected_scans [$];
    scan_result_t front_scan;

    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_req = 0;
    int hold_left = 0;

    wildcard_byte_pattern_scan_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_region_end    (i_region_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("wildcard_byte_pattern_scan_core: mismatch");
            $finish;
        end
    end

    // result side, long hold-off on request
    always @(negedge i_clk) begin
        if (stall_req != 0) begin
            hold_left = stall_req;
            stall_req = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_scans.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b addr=%08h",
                                          o_found, o_match_address));
            end else begin
                front_scan = expected_scans.pop_front();
                if (o_found !== front_scan.found)
                    report_mismatch($sformatf("found got %0b want %0b",
                                              o_found, front_scan.found));
                if (o_match_address !== front_scan.addr)
                    report_mismatch($sformatf("address got %08h want %08h",
                                              o_match_address, front_scan.addr));
            end
        end
    end

    function automatic logic [7:0] pattern_at(input int j);
        return (j < 8) ? pat_low[8*j +: 8] : pat_high[8*(j-8) +: 8];
    endfunction

    function automatic void clear_region();
        foreach (win[i]) win[i] = 8'h00;
        scan_offset = '0;
        match_seen = 1'b0;
        fill = 0;
    endfunction

    function automatic void predict_scan(input logic [7:0] b, input logic last);
        int   n;
        logic hit;
        if (!match_seen) begin
            n = (pat_len > 16) ? 16 : int'(pat_len);
            for (int i = 15; i > 0; i--) win[i] = win[i-1];
            win[0] = b;
            if (fill < 16) fill++;
            scan_offset = scan_offset + 32'd1;
            hit = (n != 0) && (fill >= n);
            for (int j = 0; j < 16; j++)
                if (hit && j < n && pattern_at(j) != WILDCARD_BYTE
                        && win[n-1-j] != pattern_at(j))
                    hit = 1'b0;
            if (hit) begin
                expected_scans.push_back('{1'b1, base_addr + scan_offset - 32'(n)});
                match_seen = 1'b1;
            end
        end
        if (last) begin
            if (!match_seen) expected_scans.push_back('{1'b0, 32'h0});
            clear_region();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_region_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_scan(b, last);
        items_sent++;
    endtask

    task automatic drain_scans();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PAT_LOW:  pat_low = val;
            CFG_PAT_HIGH: pat_high = val;
            CFG_PAT_LEN:  pat_len = val[4:0];
            CFG_BASE:     base_addr = val[31:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_region(input logic [7:0] bytes_in [$]);
        foreach (bytes_in[k]) send_byte(bytes_in[k], k == bytes_in.size() - 1);
    endtask

    task automatic test_reset_defaults();
        send_region('{8'h05, 8'hFF, 8'h00, 8'h09});
        send_region('{8'h11, 8'h22});
        send_region('{8'h00});
    endtask

    task automatic test_wildcard_match();
        drain_scans();
        write_reg(CFG_PAT_LOW, 64'h0000_0000_4443_3F41);
        write_reg(CFG_PAT_HIGH, 64'h0);
        write_reg(CFG_PAT_LEN, 64'd4);
        write_reg(CFG_BASE, 64'hFFFF_FFFE);
        // match after a two-byte lead so the address wraps, tail ignored
        send_region('{8'h55, 8'h66, 8'h41, 8'h99, 8'h43, 8'h44, 8'h77});
        // region shorter than the pattern
        send_region('{8'h41, 8'h3F});
    endtask

    task automatic test_zero_length();
        drain_scans();
        write_reg(CFG_PAT_LEN, 64'd0);
        send_region('{8'h3F, 8'h41});
    endtask

    task automatic test_length_clamp();
        drain_scans();
        write_reg(CFG_PAT_LOW, 64'h3F3F_3F3F_3F3F_3FFF);
        write_reg(CFG_PAT_HIGH, 64'h003F_3F3F_3F3F_3F3F);
        write_reg(CFG_PAT_LEN, 64'd31);
        write_reg(CFG_BASE, 64'h8000_0000);
        // full sixteen-byte match on the final byte
        send_region('{8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE,
                      8'hF0, 8'h0F, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h80, 8'h00});
    endtask

    function automatic logic [7:0] random_pattern_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return WILDCARD_BYTE;
        if (roll < 35) return 8'h00;
        if (roll < 45) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic pick_random_config();
        logic [63:0] lo, hi;
        logic [4:0]  len;
        logic [31:0] base;
        for (int j = 0; j < 8; j++) begin
            lo[8*j +: 8] = random_pattern_byte();
            hi[8*j +: 8] = random_pattern_byte();
        end
        case ($urandom_range(9))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'd17;
            4: len = 5'd31;
            default: len = 5'($urandom_range(1, 8));
        endcase
        case ($urandom_range(4))
            0: base = 32'h0;
            1: base = 32'hFFFF_FFFF;
            2: base = 32'hFFFF_FFF0;
            default: base = $urandom;
        endcase
        write_reg(CFG_PAT_LOW, lo);
        write_reg(CFG_PAT_HIGH, hi);
        write_reg(CFG_PAT_LEN, {$urandom, 27'($urandom), len});
        write_reg(CFG_BASE, {$urandom, base});
    endtask

    task automatic scan_random_region();
        logic [7:0] region_bytes [$];
        int rl, n, pos, bad, roll;
        rl = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 48);
        for (int k = 0; k < rl; k++)
            region_bytes.push_back($urandom_range(1) ? 8'($urandom)
                                                     : pattern_at($urandom_range(15)));
        n = (pat_len > 16) ? 16 : int'(pat_len);
        roll = $urandom_range(99);
        if (n > 0 && rl >= n && roll < 80) begin
            pos = $urandom_range(rl - n);
            for (int j = 0; j < n; j++)
                if (pattern_at(j) != WILDCARD_BYTE) region_bytes[pos+j] = pattern_at(j);
            // broken copy of the pattern
            if (roll >= 60) begin
                bad = $urandom_range(n - 1);
                region_bytes[pos+bad] = region_bytes[pos+bad] ^ (8'h01 << $urandom_range(7));
            end
        end
        send_region(region_bytes);
    endtask

    task automatic test_random_regions(input int tx_pct, input int rx_pct, input int target);
        int start_count;
        drain_scans();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start_count = items_sent;
        while (items_sent - start_count < target) begin
            drain_scans();
            pick_random_config();
            repeat (6) scan_random_region();
        end
    endtask

    task automatic test_output_backpressure();
        drain_scans();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_PAT_LOW, {56'h0, WILDCARD_BYTE});
        write_reg(CFG_PAT_LEN, 64'd1);
        write_reg(CFG_BASE, 64'h0000_0100);
        @(posedge i_clk);
        stall_req = 300;
        // one-byte regions, every item gives a result
        repeat (48) send_byte(8'($urandom), 1'b1);
    endtask

    initial begin
        clear_region();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_wildcard_match();
        test_zero_length();
        test_length_clamp();
        test_random_regions(21, 83, 490);
        test_random_regions(83, 21, 490);
        test_random_regions(0, 0, 490);
        test_output_backpressure();

        drain_scans();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("wildcard_byte_pattern_scan_core: match");
        end else begin
            $display("wildcard_byte_pattern_scan_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: wildcard_byte_pattern_scan_core.f
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_cell.sv
sv/wildcard_byte_pattern_scan_core.sv
sv/wbps_checker.sv
verif/tb_top.sv
